>>> sv/ship_rrip_stream_replacement_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SHiP/RRIP replacement block
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHIP_RRIP_STREAM_REPLACEMENT_DEFINES_SVH
`define SHIP_RRIP_STREAM_REPLACEMENT_DEFINES_SVH

// Same-cycle implication
`define SHRRIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHRRIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/shrrip_pkg.sv
// ----------------------------------------------------------------------------
// shrrip_pkg
// Shared constants for the SHiP-lite / SRRIP replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shrrip_pkg;

  localparam int NUM_SETS_DEF = 2048;
  localparam int NUM_WAYS_DEF = 16;
  localparam int SIG_BITS_DEF = 6;

  // fixed field widths
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int ADDR_W   = 64;
  localparam int PC_SIG_W = 6;
  localparam int VICTIM_W = 4;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] RRPV_TOP  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] CTR_TOP   = 2'd3;
  localparam logic [1:0] CTR_INIT  = 2'd1;
  localparam logic [1:0] CTR_HIGH  = 2'd2;
  localparam logic [1:0] STRM_TOP  = 2'd3;

  localparam logic [ADDR_W-1:0] STRIDE_A = 64'd64;
  localparam logic [ADDR_W-1:0] STRIDE_B = 64'd128;
  localparam logic [ADDR_W-1:0] STRIDE_C = 64'd256;

endpackage

>>> sv/shrrip_scan.sv
// ----------------------------------------------------------------------------
// shrrip_scan
// Row unit: first way at distant RRPV, and the row aged by one step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shrrip_scan #(
  parameter int NUM_WAYS = shrrip_pkg::NUM_WAYS_DEF
) (
  input  logic [2*NUM_WAYS-1:0]       row,
  output logic                        found,
  output logic [$clog2(NUM_WAYS)-1:0] first_way,
  output logic [2*NUM_WAYS-1:0]       aged_row
);
  import shrrip_pkg::*;

  localparam int WAY_W = $clog2(NUM_WAYS);

  // walk downward so the lowest matching way wins
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[2*w +: 2] == RRPV_TOP) begin
        found     = 1'b1;
        first_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = (row[2*w +: 2] == RRPV_TOP) ? RRPV_TOP : row[2*w +: 2] + 2'd1;
    end
  end

endmodule

>>> sv/ship_rrip_stream_replacement.sv
// ----------------------------------------------------------------------------
// ship_rrip_stream_replacement
// 2-bit SRRIP with a SHiP-lite reuse table and a per-set stream detector.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall  | command, set_index, way_index,
//          |           |                      | access_address, pc_signature, hit
//  out     | from block| out_valid / out_stall| victim_way (find-victim only)
//
//  Victim: transfer, row read, scan; the row is aged and scanned again when
//  no way is distant. Update: row read, stream train, counter
//  read-modify-write, then on a miss an insert.
//  A set_index at or above NUM_SETS first passes a shift-subtract reduction.
//  After reset a clearing pass over every row and reuse counter runs with
//  in_stall high. A stalled result holds the scan until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ship_rrip_stream_replacement_defines.svh"

module ship_rrip_stream_replacement #(
  parameter int NUM_SETS = shrrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = shrrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS = shrrip_pkg::SIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [shrrip_pkg::SET_IN_W-1:0] set_index,
  input  logic [shrrip_pkg::WAY_IN_W-1:0] way_index,
  input  logic [shrrip_pkg::ADDR_W-1:0]   access_address,
  input  logic [shrrip_pkg::PC_SIG_W-1:0] pc_signature,
  input  logic                          hit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shrrip_pkg::VICTIM_W-1:0] victim_way
);
  import shrrip_pkg::*;

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_BITS;
  localparam int ROW_W     = 2 * NUM_WAYS;
  localparam int SROW_W    = SIG_BITS * NUM_WAYS;
  localparam int SETM_W    = ADDR_W + 2;
  localparam int CLR_LEN   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
  localparam int CLR_W     = $clog2(CLR_LEN + 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_REDUCE = 8'b0000_0100,
    S_ISSUE  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_STREAM = 8'b0010_0000,
    S_CTR    = 8'b0100_0000,
    S_INS    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CLR_W-1:0]    clr_cnt;
  logic                cmd_r;
  logic [SET_IN_W-1:0] set_r;
  logic [WAY_W-1:0]    way_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SIG_BITS-1:0] sig_r;
  logic                hit_r;
  logic [3:0]          red_k;
  logic                aged;
  logic [SIG_BITS-1:0] old_sig_r;
  logic [1:0]          cnt_new_r;
  logic                fwd_r;
  logic [1:0]          fwd_val_r;

  // memories
  logic [ROW_W-1:0]  rrpv_mem  [NUM_SETS];
  logic [SROW_W-1:0] sig_mem   [NUM_SETS];
  logic [SETM_W-1:0] set_mem   [NUM_SETS];
  logic [1:0]        reuse_mem [SIG_COUNT];
  logic [ROW_W-1:0]  rrpv_rd;
  logic [SROW_W-1:0] sig_rd;
  logic [SETM_W-1:0] set_rd;
  logic [1:0]        reuse_rd;

  logic              accept;
  logic              in_range;
  logic [WAY_IN_W:0] way_rem;
  logic [WAY_W-1:0]  way_red;
  logic [PC_SIG_W+SIG_BITS-1:0] sig_ext;
  logic [SIG_BITS-1:0] sig_in;
  logic [31:0]       red_div;
  logic [SET_W-1:0]  set_addr;
  logic [SET_W-1:0]  row_waddr;
  logic              row_re;
  logic              rrpv_we, sig_we, set_we, age_load;
  logic [ROW_W-1:0]  rrpv_wdata;
  logic [SROW_W-1:0] sig_wdata;
  logic [SETM_W-1:0] set_wdata;
  logic              reuse_we, reuse_re;
  logic [SIG_BITS-1:0] reuse_waddr, reuse_raddr;
  logic [1:0]        reuse_wdata;
  logic              found;
  logic [WAY_W-1:0]  first_way;
  logic [ROW_W-1:0]  aged_row;
  logic              slot_free;
  logic              out_load;
  logic [WAY_W+VICTIM_W-1:0] out_ext;
  logic [ADDR_W-1:0] prev_addr, delta;
  logic [1:0]        cnt_old, cnt_new;
  logic              near;
  logic [SIG_BITS-1:0] old_sig;
  logic [1:0]        ctr_inc, ctr_dec, ins_ctr, ins_rrpv;
  logic [ROW_W-1:0]  rrpv_row_upd;
  logic [SROW_W-1:0] sig_row_upd;
  logic [1:0]        upd_rrpv;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_range = (32'(set_index) < 32'(NUM_SETS));
  assign set_addr = SET_W'(set_r);
  assign slot_free = !out_valid || !out_stall;

  // way_index mod NUM_WAYS by shift-subtract over the four input bits
  always_comb begin
    way_rem = (WAY_IN_W+1)'(way_index);
    for (int k = WAY_IN_W - 1; k >= 0; k--) begin
      if (32'(way_rem) >= 32'(NUM_WAYS << k)) begin
        way_rem = way_rem - (WAY_IN_W+1)'(NUM_WAYS << k);
      end
    end
    way_red = WAY_W'(way_rem);
  end

  assign sig_ext = (PC_SIG_W+SIG_BITS)'(pc_signature);
  assign sig_in  = sig_ext[SIG_BITS-1:0];
  assign red_div = 32'(NUM_SETS) << red_k;

  shrrip_scan #(.NUM_WAYS(NUM_WAYS)) u_scan (
    .row       (rrpv_rd),
    .found     (found),
    .first_way (first_way),
    .aged_row  (aged_row)
  );

  // stream training: one subtract, matched against the strides both ways
  always_comb begin
    prev_addr = set_rd[SETM_W-1:2];
    cnt_old   = set_rd[1:0];
    delta     = addr_r - prev_addr;
    near      = (prev_addr != '0) &&
                (delta == STRIDE_A || delta == STRIDE_B || delta == STRIDE_C ||
                 delta == ('0 - STRIDE_A) || delta == ('0 - STRIDE_B) ||
                 delta == ('0 - STRIDE_C));
    if (near) begin
      cnt_new = (cnt_old == STRM_TOP) ? cnt_old : cnt_old + 2'd1;
    end else begin
      cnt_new = (cnt_old == 2'd0) ? cnt_old : cnt_old - 2'd1;
    end
  end

  assign old_sig = sig_rd[way_r*SIG_BITS +: SIG_BITS];
  assign ctr_inc = (reuse_rd == CTR_TOP) ? reuse_rd : reuse_rd + 2'd1;
  assign ctr_dec = (reuse_rd == 2'd0) ? reuse_rd : reuse_rd - 2'd1;
  assign ins_ctr = fwd_r ? fwd_val_r : reuse_rd;
  assign ins_rrpv = (cnt_new_r == STRM_TOP) ? RRPV_TOP :
                    ((ins_ctr >= CTR_HIGH) ? RRPV_NEAR : RRPV_TOP);
  assign upd_rrpv = (state == S_INS) ? ins_rrpv : RRPV_NEAR;

  always_comb begin
    rrpv_row_upd = rrpv_rd;
    rrpv_row_upd[way_r*2 +: 2] = upd_rrpv;
    sig_row_upd = sig_rd;
    sig_row_upd[way_r*SIG_BITS +: SIG_BITS] = sig_r;
  end

  // sequencer controls
  always_comb begin
    state_next  = state;
    row_waddr   = set_addr;
    row_re      = 1'b0;
    rrpv_we     = 1'b0;
    sig_we      = 1'b0;
    set_we      = 1'b0;
    age_load    = 1'b0;
    rrpv_wdata  = rrpv_row_upd;
    sig_wdata   = sig_row_upd;
    set_wdata   = {addr_r, cnt_new};
    reuse_we    = 1'b0;
    reuse_re    = 1'b0;
    reuse_waddr = sig_r;
    reuse_raddr = sig_r;
    reuse_wdata = ctr_inc;
    out_load    = 1'b0;
    case (state)
      S_CLEAR: begin
        row_waddr  = SET_W'(clr_cnt);
        rrpv_wdata = {NUM_WAYS{RRPV_TOP}};
        sig_wdata  = '0;
        set_wdata  = '0;
        rrpv_we    = (32'(clr_cnt) < 32'(NUM_SETS));
        sig_we     = rrpv_we;
        set_we     = rrpv_we;
        reuse_we    = (32'(clr_cnt) < 32'(SIG_COUNT));
        reuse_waddr = SIG_BITS'(clr_cnt);
        reuse_wdata = CTR_INIT;
        if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_range ? S_ISSUE : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (red_k == 4'd0) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        row_re     = 1'b1;
        state_next = (cmd_r == CMD_VICTIM) ? S_SCAN : S_STREAM;
      end
      S_SCAN: begin
        if (!found && !aged) begin
          // nothing distant: age the whole row once and scan again
          rrpv_we    = 1'b1;
          rrpv_wdata = aged_row;
          age_load   = 1'b1;
        end else if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        set_we      = 1'b1;
        reuse_re    = 1'b1;
        reuse_raddr = hit_r ? sig_r : old_sig;
        state_next  = S_CTR;
      end
      S_CTR: begin
        reuse_we = 1'b1;
        if (hit_r) begin
          reuse_wdata = ctr_inc;
          rrpv_we     = 1'b1;
          sig_we      = 1'b1;
          state_next  = S_IDLE;
        end else begin
          reuse_waddr = old_sig_r;
          reuse_wdata = ctr_dec;
          reuse_re    = 1'b1;
          state_next  = S_INS;
        end
      end
      S_INS: begin
        rrpv_we    = 1'b1;
        sig_we     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rrpv_we) begin
      rrpv_mem[row_waddr] <= rrpv_wdata;
    end
    if (row_re) begin
      rrpv_rd <= rrpv_mem[set_addr];
    end else if (age_load) begin
      rrpv_rd <= aged_row;
    end
  end

  always_ff @(posedge clk) begin
    if (sig_we) begin
      sig_mem[row_waddr] <= sig_wdata;
    end
    if (row_re) begin
      sig_rd <= sig_mem[set_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (set_we) begin
      set_mem[row_waddr] <= set_wdata;
    end
    if (row_re) begin
      set_rd <= set_mem[set_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (reuse_we) begin
      reuse_mem[reuse_waddr] <= reuse_wdata;
    end
    if (reuse_re) begin
      reuse_rd <= reuse_mem[reuse_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      aged      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (state == S_ISSUE) begin
        aged <= 1'b0;
      end else if (age_load) begin
        aged <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= command;
      set_r  <= set_index;
      way_r  <= way_red;
      addr_r <= access_address;
      sig_r  <= sig_in;
      hit_r  <= hit;
      red_k  <= 4'(SET_IN_W - 1);
    end else if (state == S_REDUCE) begin
      if (32'(set_r) >= red_div) begin
        set_r <= set_r - SET_IN_W'(red_div);
      end
      red_k <= red_k - 4'd1;
    end
    if (state == S_STREAM) begin
      cnt_new_r <= cnt_new;
      old_sig_r <= old_sig;
    end
    if (state == S_CTR) begin
      fwd_r     <= (sig_r == old_sig_r);
      fwd_val_r <= ctr_dec;
    end
    if (out_load) begin
      victim_way <= out_ext[VICTIM_W-1:0];
    end
  end

  assign out_ext = found ? (WAY_W+VICTIM_W)'(first_way) : '0;

  `SHRRIP_ASSERT_IMP(a_clear_stalls, state == S_CLEAR, in_stall, "input taken during clear pass")
  `SHRRIP_ASSERT_NXT(a_update_no_result, accept && command == CMD_UPDATE && !out_valid, !out_valid, "update produced a result")
  `SHRRIP_ASSERT_NXT(a_age_once, state == S_SCAN && !found && !aged, state == S_SCAN && aged, "aging step did not rescan")

endmodule

>>> tb/tb_ship_rrip_stream_replacement.sv
// ----------------------------------------------------------------------------
// tb_ship_rrip_stream_replacement
// Self-checking bench for the SHiP-lite / SRRIP replacement block. A shadow
// copy of the RRPV rows, signature table and stream detector predicts each
// find-victim result. Directed accesses come first, then random traffic
// built from single accesses, fill bursts, stride runs and noise, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ship_rrip_stream_replacement;
  import shrrip_pkg::*;

  localparam int NSETS = NUM_SETS_DEF;
  localparam int NWAYS = NUM_WAYS_DEF;
  localparam int NSIGS = 1 << SIG_BITS_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES = 400;

  class ship_rrip_shadow;
    bit [1:0]        rrpv_row [NSETS*NWAYS];
    bit [5:0]        sig_of_block [NSETS*NWAYS];
    bit [1:0]        reuse_ctr [NSIGS];
    bit [ADDR_W-1:0] addr_seen [NSETS];
    bit [1:0]        stream_ctr [NSETS];
    bit [VICTIM_W-1:0] victim_fifo [$];
    int errors;

    function new();
      foreach (rrpv_row[i]) rrpv_row[i] = RRPV_TOP;
      foreach (sig_of_block[i]) sig_of_block[i] = '0;
      foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_INIT;
      foreach (addr_seen[i]) addr_seen[i] = '0;
      foreach (stream_ctr[i]) stream_ctr[i] = '0;
      errors = 0;
    endfunction

    function int first_distant(int base);
      for (int w = 0; w < NWAYS; w++)
        if (rrpv_row[base + w] == RRPV_TOP) return w;
      return -1;
    endfunction

    // called on every accepted input transfer
    function void note_transfer(bit cmd, bit [SET_IN_W-1:0] set_i, bit [WAY_IN_W-1:0] way_i,
                                bit [ADDR_W-1:0] addr, bit [PC_SIG_W-1:0] pc_sig, bit is_hit);
      int set_n;
      int base;
      int idx;
      int found;
      bit [5:0] sig;
      bit [5:0] old_sig;
      bit [ADDR_W-1:0] prev;
      bit [ADDR_W-1:0] delta;
      bit near;
      set_n = int'(set_i) % NSETS;
      base = set_n * NWAYS;
      idx = base + int'(way_i) % NWAYS;
      sig = pc_sig & (NSIGS - 1);
      if (cmd == CMD_VICTIM) begin
        found = first_distant(base);
        if (found < 0) begin
          for (int w = 0; w < NWAYS; w++)
            if (rrpv_row[base + w] < RRPV_TOP) rrpv_row[base + w]++;
          found = first_distant(base);
          if (found < 0) found = 0;
        end
        victim_fifo.push_back(found[VICTIM_W-1:0]);
        return;
      end
      // stream detector; a zero last address means nothing is known yet
      prev = addr_seen[set_n];
      near = 1'b0;
      if (prev != '0) begin
        delta = (addr > prev) ? addr - prev : prev - addr;
        near = (delta == STRIDE_A) || (delta == STRIDE_B) || (delta == STRIDE_C);
      end
      if (near) begin
        if (stream_ctr[set_n] < STRM_TOP) stream_ctr[set_n]++;
      end else if (stream_ctr[set_n] > 0) begin
        stream_ctr[set_n]--;
      end
      addr_seen[set_n] = addr;
      if (is_hit) begin
        rrpv_row[idx] = RRPV_NEAR;
        sig_of_block[idx] = sig;
        if (reuse_ctr[sig] < CTR_TOP) reuse_ctr[sig]++;
        return;
      end
      old_sig = sig_of_block[idx] & (NSIGS - 1);
      if (reuse_ctr[old_sig] > 0) reuse_ctr[old_sig]--;
      if (stream_ctr[set_n] >= STRM_TOP)
        rrpv_row[idx] = RRPV_TOP;
      else
        rrpv_row[idx] = (reuse_ctr[sig] >= CTR_HIGH) ? RRPV_NEAR : RRPV_TOP;
      sig_of_block[idx] = sig;
    endfunction

    function void check_victim(bit [VICTIM_W-1:0] got);
      bit [VICTIM_W-1:0] want;
      if (victim_fifo.size() == 0) begin
        if (errors < 10) $display("unexpected result: victim_way=%0d", got);
        errors++;
        return;
      end
      want = victim_fifo.pop_front();
      if (got !== want) begin
        if (errors < 10) $display("victim_way mismatch: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                command;
  logic [SET_IN_W-1:0] set_index;
  logic [WAY_IN_W-1:0] way_index;
  logic [ADDR_W-1:0]   access_address;
  logic [PC_SIG_W-1:0] pc_signature;
  logic                hit;
  logic                out_valid;
  logic                out_stall;
  logic [VICTIM_W-1:0] victim_way;

  ship_rrip_shadow shadow;
  bit calm;
  bit hold_req;
  int sent;
  bit [SET_IN_W-1:0] set_pool [4];

  ship_rrip_stream_replacement u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .set_index      (set_index),
    .way_index      (way_index),
    .access_address (access_address),
    .pc_signature   (pc_signature),
    .hit            (hit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .victim_way     (victim_way)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial shadow = new();

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) shadow.check_victim(victim_way);
  end

  // receiver stall pattern, including one long hold-off
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  task automatic send(bit cmd, bit [SET_IN_W-1:0] s, bit [WAY_IN_W-1:0] w,
                      bit [ADDR_W-1:0] a, bit [PC_SIG_W-1:0] g, bit h);
    in_valid       <= 1'b1;
    command        <= cmd;
    set_index      <= s;
    way_index      <= w;
    access_address <= a;
    pc_signature   <= g;
    hit            <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_transfer(cmd, s, w, a, g, h);
    sent++;
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // drop valid first so the last transfer is not taken again while waiting
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.victim_fifo.size() != 0) @(posedge clk);
  endtask

  function automatic bit [ADDR_W-1:0] next_addr(bit [SET_IN_W-1:0] s);
    bit [ADDR_W-1:0] prev;
    bit [ADDR_W-1:0] stride;
    prev = shadow.addr_seen[int'(s) % NSETS];
    case ($urandom_range(2))
      0: stride = STRIDE_A;
      1: stride = STRIDE_B;
      default: stride = STRIDE_C;
    endcase
    if (prev == '0) return {$urandom, $urandom} & ~64'h3f;
    if ($urandom_range(9) == 0) return prev + $urandom_range(1000);  // broken stride
    return $urandom_range(1) ? prev + stride : prev - stride;
  endfunction

  function automatic bit [PC_SIG_W-1:0] pick_sig();
    return ($urandom_range(9) < 7) ? PC_SIG_W'($urandom_range(7)) : PC_SIG_W'($urandom);
  endfunction

  task automatic single_access();
    bit [SET_IN_W-1:0] s;
    bit [ADDR_W-1:0] a;
    s = set_pool[$urandom_range(3)];
    case ($urandom_range(19))
      0: a = '0;
      1, 2, 3, 4, 5, 6, 7, 8, 9: a = {$urandom, $urandom};
      default: a = next_addr(s);
    endcase
    send($urandom_range(1) ? CMD_UPDATE : CMD_VICTIM, s, WAY_IN_W'($urandom), a,
         pick_sig(), $urandom_range(1));
  endtask

  // every way of a set hit, then victims that need aging or fall back to way 0
  task automatic fill_burst();
    bit [SET_IN_W-1:0] s;
    s = set_pool[$urandom_range(3)];
    for (int w = 0; w < NWAYS; w++)
      send(CMD_UPDATE, s, WAY_IN_W'(w), next_addr(s), pick_sig(), 1'b1);
    repeat ($urandom_range(1, 4))
      send(CMD_VICTIM, s, WAY_IN_W'($urandom), {$urandom, $urandom}, PC_SIG_W'($urandom),
           $urandom_range(1));
  endtask

  // stride run of updates, mostly misses, to trip the stream detector, then a victim
  task automatic stride_run();
    bit [SET_IN_W-1:0] s;
    s = set_pool[$urandom_range(3)];
    repeat ($urandom_range(3, 7))
      send(CMD_UPDATE, s, WAY_IN_W'($urandom), next_addr(s), pick_sig(),
           $urandom_range(4) == 0);
    send(CMD_VICTIM, s, WAY_IN_W'($urandom), '0, '0, 1'b0);
  endtask

  task automatic noise();
    send($urandom_range(1) ? CMD_UPDATE : CMD_VICTIM, SET_IN_W'($urandom), WAY_IN_W'($urandom),
         {$urandom, $urandom}, PC_SIG_W'($urandom), $urandom_range(1));
  endtask

  initial begin
    calm = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_VICTIM;
    set_index <= '0;
    way_index <= '0;
    access_address <= '0;
    pc_signature <= '0;
    hit <= 1'b0;
    set_pool[0] = '0;
    set_pool[1] = '1;
    set_pool[2] = SET_IN_W'($urandom);
    set_pool[3] = SET_IN_W'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed
    send(CMD_VICTIM, 0, 0, '0, '0, 1'b0);
    send(CMD_UPDATE, 0, 0, '0, 0, 1'b1);                    // zero address, first touch
    send(CMD_UPDATE, 0, 1, 64'h1000, 63, 1'b0);
    send(CMD_UPDATE, 0, 2, 64'h1040, 63, 1'b0);              // +64
    send(CMD_UPDATE, 0, 3, 64'h10c0, 5, 1'b0);               // +128
    send(CMD_UPDATE, 0, 4, 64'h11c0, 0, 1'b0);               // +256, stream saturates
    send(CMD_UPDATE, 0, 5, 64'h1180, 0, 1'b0);               // -64, streaming insert
    send(CMD_VICTIM, 0, 0, '0, '0, 1'b0);
    send(CMD_UPDATE, 0, 6, 64'h5000, 0, 1'b0);               // non-stride delta
    send(CMD_UPDATE, 0, 15, '0, 63, 1'b1);                   // current address zero
    send(CMD_UPDATE, 0, 7, 64'h40, 63, 1'b0);                // prev zero, delta 64 ignored
    send(CMD_VICTIM, 0, 0, '0, '0, 1'b0);
    send(CMD_VICTIM, 0, 0, '0, '0, 1'b0);
    send(CMD_UPDATE, '1, 15, '1, 63, 1'b1);
    send(CMD_VICTIM, '1, 15, '1, 63, 1'b1);
    send(CMD_UPDATE, '1, 15, 64'hffff_ffff_ffff_feff, 0, 1'b0);
    send(CMD_VICTIM, '1, 0, '0, '0, 1'b0);
    wait_drained();

    // random
    while (sent < RANDOM_ITEMS + 17) begin
      calm = (sent >= 120) && (sent < 260);
      if (sent >= 380 && !hold_req) hold_req = 1'b1;
      if (sent >= 520 && sent < 540) wait_drained();
      case ($urandom_range(9))
        0, 1, 2, 3: single_access();
        4, 5:       fill_burst();
        6, 7, 8:    stride_run();
        default:    noise();
      endcase
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (shadow.errors == 0 && shadow.victim_fifo.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/shrrip_pkg.sv
sv/shrrip_scan.sv
sv/ship_rrip_stream_replacement.sv
tb/tb_ship_rrip_stream_replacement.sv
